### design/spom_pkg.sv
// Shared types, constants and codes for the spiral-order matrix scan.
package spom_pkg;

  // Field and register widths fixed by the interface
  localparam int CNT_W      = 4;          // row_count / col_count width
  localparam int TOT_W      = 2 * CNT_W;  // element count and linear address width
  localparam int IDX_W      = 3;          // row_index / col_index width
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index codes (word address bit 2)
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  // Register reset values
  localparam logic [CNT_W-1:0] RESET_ROW_COUNT = 4'd8;
  localparam logic [CNT_W-1:0] RESET_COL_COUNT = 4'd8;

  // Parameter defaults
  localparam int DEF_MAX_ROWS   = 8;
  localparam int DEF_MAX_COLS   = 8;
  localparam int DEF_DATA_WIDTH = 32;

  // Top-level control state
  typedef enum logic {
    ST_LOAD,
    ST_BURST
  } state_t;

  // Current leg of the spiral walk
  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_t;

  // Position handed from the walker to the output stage
  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             last;
  } walk_pos_t;

endpackage

### design/spom_store.sv
// Matrix element memory: one write port, one registered read port.
module spom_store #(
  parameter int DATA_WIDTH = spom_pkg::DEF_DATA_WIDTH,
  parameter int DEPTH      = spom_pkg::DEF_MAX_ROWS * spom_pkg::DEF_MAX_COLS,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/spom_walker.sv
// Spiral walk sequencer: steps row/column through the rings and forms the address.
module spom_walker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       step,
  input  logic [spom_pkg::CNT_W-1:0] rows,
  input  logic [spom_pkg::CNT_W-1:0] cols,
  input  logic [spom_pkg::TOT_W-1:0] total,
  output spom_pkg::walk_pos_t        pos,
  output logic [spom_pkg::TOT_W-1:0] addr
);

  localparam int CW = spom_pkg::CNT_W;
  localparam int TW = spom_pkg::TOT_W;

  spom_pkg::dir_t dir_r, dir_nxt;
  logic [CW-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [CW-1:0]  sr_r, sr_nxt, er_r, er_nxt, sc_r, sc_nxt, ec_r, ec_nxt;
  logic [TW-1:0]  cnt_r, cnt_nxt;
  logic [TW-1:0]  prod;

  // Direction and step-count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= spom_pkg::DIR_RIGHT;
      cnt_r <= '0;
    end else begin
      dir_r <= dir_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Position and ring bounds
  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
    sr_r  <= sr_nxt;
    er_r  <= er_nxt;
    sc_r  <= sc_nxt;
    ec_r  <= ec_nxt;
  end

  // Next position: advance along the leg, turn at a corner, or move one ring in
  always_comb begin
    dir_nxt = dir_r;
    row_nxt = row_r;
    col_nxt = col_r;
    sr_nxt  = sr_r;
    er_nxt  = er_r;
    sc_nxt  = sc_r;
    ec_nxt  = ec_r;
    cnt_nxt = cnt_r;
    if (start) begin
      dir_nxt = spom_pkg::DIR_RIGHT;
      row_nxt = '0;
      col_nxt = '0;
      sr_nxt  = '0;
      er_nxt  = rows - CW'(1);
      sc_nxt  = '0;
      ec_nxt  = cols - CW'(1);
      cnt_nxt = '0;
    end else if (step) begin
      cnt_nxt = cnt_r + TW'(1);
      case (dir_r)
        spom_pkg::DIR_RIGHT: begin
          if (col_r < ec_r) begin
            col_nxt = col_r + CW'(1);
          end else if (row_r < er_r) begin
            row_nxt = row_r + CW'(1);
            dir_nxt = spom_pkg::DIR_DOWN;
          end
        end
        spom_pkg::DIR_DOWN: begin
          if (row_r < er_r) begin
            row_nxt = row_r + CW'(1);
          end else if (col_r > sc_r) begin
            col_nxt = col_r - CW'(1);
            dir_nxt = spom_pkg::DIR_LEFT;
          end
        end
        spom_pkg::DIR_LEFT: begin
          if (col_r > sc_r) begin
            col_nxt = col_r - CW'(1);
          end else if (row_r > sr_r + CW'(1)) begin
            row_nxt = row_r - CW'(1);
            dir_nxt = spom_pkg::DIR_UP;
          end else begin
            sr_nxt  = sr_r + CW'(1);
            er_nxt  = er_r - CW'(1);
            sc_nxt  = sc_r + CW'(1);
            ec_nxt  = ec_r - CW'(1);
            row_nxt = sr_r + CW'(1);
            col_nxt = sc_r + CW'(1);
            dir_nxt = spom_pkg::DIR_RIGHT;
          end
        end
        spom_pkg::DIR_UP: begin
          if (row_r > sr_r + CW'(1)) begin
            row_nxt = row_r - CW'(1);
          end else begin
            sr_nxt  = sr_r + CW'(1);
            er_nxt  = er_r - CW'(1);
            sc_nxt  = sc_r + CW'(1);
            ec_nxt  = ec_r - CW'(1);
            row_nxt = sr_r + CW'(1);
            col_nxt = sc_r + CW'(1);
            dir_nxt = spom_pkg::DIR_RIGHT;
          end
        end
        default: begin
          dir_nxt = spom_pkg::DIR_RIGHT;
        end
      endcase
    end
  end

  // Row-major address of the current element
  assign prod = TW'(row_r) * TW'(cols);
  assign addr = prod + TW'(col_r);

  assign pos.row  = row_r;
  assign pos.col  = col_r;
  assign pos.last = (cnt_r == total - TW'(1));

endmodule

### design/spiral_order_matrix_scan.sv
// Top level of the spiral-order matrix scan: load, config registers and result stage.
//
//   channel   | direction | handshake            | payload
//   in_       | input     | in_valid / in_stall  | in_element_value
//   out_      | output    | out_valid / out_stall| out_value, out_row_index, out_col_index,
//             |           |                      | out_last_of_run
//   cfg_      | input     | APB write/read       | row_count (0x0), col_count (0x4)
//
// Loading accepts one element per cycle while in_stall is low. The completing element
// starts a burst of rows*cols results, one per cycle while out_stall is low, set by
// the single memory read port; the first read issues once the state register enters
// the burst state. in_stall is high in that state, which the last read issue ends.
// Reset (rst_n, synchronous) clears the load count and sets both counts to 8.
// A stalled result holds in the read-data register and pauses the walk.
module spiral_order_matrix_scan #(
  parameter int MAX_ROWS   = spom_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = spom_pkg::DEF_MAX_COLS,
  parameter int DATA_WIDTH = spom_pkg::DEF_DATA_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [DATA_WIDTH-1:0]      in_element_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [DATA_WIDTH-1:0]      out_value,
  output logic [spom_pkg::IDX_W-1:0]        out_row_index,
  output logic [spom_pkg::IDX_W-1:0]        out_col_index,
  output logic                              out_last_of_run,
  // configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [spom_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [spom_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [spom_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int CW    = spom_pkg::CNT_W;
  localparam int TW    = spom_pkg::TOT_W;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (AW > TW) ? AW : TW;

  spom_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]       row_count_r, col_count_r;
  logic [TW-1:0]       load_cnt_r;
  logic                out_valid_r;
  spom_pkg::walk_pos_t meta_r;

  logic [CW-1:0]       rows_eff, cols_eff;
  logic [TW-1:0]       total;
  logic                in_acc, cfg_wr, complete, issue, start;
  logic [XW-1:0]       waddr_x, raddr_x;
  logic [TW-1:0]       walk_addr;
  spom_pkg::walk_pos_t pos;
  logic [DATA_WIDTH-1:0] rdata;

  // Clamp the configured counts into 1..MAX
  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = CW'(1);
    end else if (int'(row_count_r) > MAX_ROWS) begin
      rows_eff = CW'(MAX_ROWS);
    end else begin
      rows_eff = row_count_r;
    end
    if (col_count_r == '0) begin
      cols_eff = CW'(1);
    end else if (int'(col_count_r) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = col_count_r;
    end
  end

  assign total = TW'(rows_eff) * TW'(cols_eff);

  // Handshakes
  assign in_stall  = (state_r == spom_pkg::ST_BURST);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign complete  = ({1'b0, load_cnt_r} + (TW+1)'(1)) >= {1'b0, total};
  assign start     = in_acc && complete;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spom_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state; in the burst state a read issues whenever the result register is free or draining
  always_comb begin
    state_nxt = state_r;
    issue     = 1'b0;
    case (state_r)
      spom_pkg::ST_LOAD: begin
        if (start) begin
          state_nxt = spom_pkg::ST_BURST;
        end
      end
      spom_pkg::ST_BURST: begin
        issue = !out_valid_r || !out_stall;
        if (issue && pos.last) begin
          state_nxt = spom_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = spom_pkg::ST_LOAD;
      end
    endcase
  end

  // Config registers and load counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= spom_pkg::RESET_ROW_COUNT;
      col_count_r <= spom_pkg::RESET_COL_COUNT;
      load_cnt_r  <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == spom_pkg::REG_ROW_COUNT) begin
        row_count_r <= cfg_pwdata[CW-1:0];
      end else begin
        col_count_r <= cfg_pwdata[CW-1:0];
      end
      load_cnt_r <= '0;
    end else if (in_acc) begin
      load_cnt_r <= complete ? '0 : load_cnt_r + TW'(1);
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (issue) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result position, captured with the read
  always_ff @(posedge clk) begin
    if (issue) begin
      meta_r <= pos;
    end
  end

  // Register reads
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == spom_pkg::REG_COL_COUNT) ?
                      spom_pkg::CFG_DATA_W'(col_count_r) :
                      spom_pkg::CFG_DATA_W'(row_count_r);

  spom_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .step  (issue),
    .rows  (rows_eff),
    .cols  (cols_eff),
    .total (total),
    .pos   (pos),
    .addr  (walk_addr)
  );

  assign waddr_x = XW'(load_cnt_r);
  assign raddr_x = XW'(walk_addr);

  spom_store #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (waddr_x[AW-1:0]),
    .wdata (in_element_value),
    .re    (issue),
    .raddr (raddr_x[AW-1:0]),
    .rdata (rdata)
  );

  // Result ports
  assign out_valid       = out_valid_r;
  assign out_value       = rdata;
  assign out_row_index   = meta_r.row[spom_pkg::IDX_W-1:0];
  assign out_col_index   = meta_r.col[spom_pkg::IDX_W-1:0];
  assign out_last_of_run = meta_r.last;

`ifndef NO_ASSERTIONS
  // A stalled result stays put until it is taken
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_value) &&
      $stable(out_row_index) && $stable(out_col_index) && $stable(out_last_of_run)))
    else $error("stalled result changed");

  // An empty result register during a burst is refilled next cycle
  a_burst_refills: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spom_pkg::ST_BURST && !out_valid) |=> out_valid)
    else $error("burst left the result register empty");

  // The completing element starts a burst
  a_complete_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && complete) |=> (state_r == spom_pkg::ST_BURST))
    else $error("completed matrix did not start a burst");
`endif

endmodule
